// ===== rtl/height_blended_texture_color_defines.svh =====
// ----------------------------------------------------------------------------
// height_blended_texture_color_defines.svh
// Assertion macros for the height blended texture color block. In synthesis
// they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_BLENDED_TEXTURE_COLOR_DEFINES_SVH
`define HEIGHT_BLENDED_TEXTURE_COLOR_DEFINES_SVH

`ifndef SYNTHESIS

// checked property, quiet while reset is high
`define HBTC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hbtc assertion failed");

// checked property, also active during reset
`define HBTC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hbtc assertion failed");

`else

`define HBTC_ASSERT(label, clk, rst, prop)
`define HBTC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/hbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbtc_pkg
// Shared types, constants and stream layout of the height blended texture
// color block.
// ----------------------------------------------------------------------------
package hbtc_pkg;

  // default texture geometry
  localparam int DEF_TEX_WIDTH  = 256;
  localparam int DEF_TEX_HEIGHT = 256;
  localparam int DEF_TEX_COUNT  = 8;

  // item kind carried in tuser
  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_SHADE = 1'b1
  } mode_t;

  // detail level register
  localparam int DETAIL_W = 4;
  typedef logic signed [DETAIL_W-1:0] detail_t;
  localparam detail_t DETAIL_RESET = '0;

  // field widths
  localparam int SEL_W    = 3;
  localparam int IDX_W    = 16;
  localparam int CHAN_W   = 8;
  localparam int TEXEL_W  = 3 * CHAN_W;
  localparam int HEIGHT_W = 16;
  localparam int COORD_W  = 21;

  // input tdata layout, lowest field first
  localparam int SEL_LSB    = 0;
  localparam int IDX_LSB    = SEL_LSB + SEL_W;
  localparam int RED_LSB    = IDX_LSB + IDX_W;
  localparam int GREEN_LSB  = RED_LSB + CHAN_W;
  localparam int BLUE_LSB   = GREEN_LSB + CHAN_W;
  localparam int HEIGHT_LSB = BLUE_LSB + CHAN_W;
  localparam int CX_LSB     = HEIGHT_LSB + HEIGHT_W;
  localparam int CY_LSB     = CX_LSB + COORD_W;
  localparam int S_FIELDS_W = CY_LSB + COORD_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = TEXEL_W;

  // height to blend position, 14 fraction bits
  localparam int FRAC_BITS    = 14;
  localparam int FRAC_ONE     = 1 << FRAC_BITS;
  localparam int HEIGHT_BIAS  = 8192;
  localparam int HEIGHT_SCALE = 7;
  localparam int Z_MAX        = (HEIGHT_SCALE << FRAC_BITS) - 1;
  localparam int Z_W          = 17;
  localparam int ZRAW_W       = 21;
  localparam int ZI_W         = Z_W - FRAC_BITS;

  // blend arithmetic
  localparam int WEIGHT_W = FRAC_BITS + 1;
  localparam int PROD_W   = CHAN_W + WEIGHT_W;
  localparam int SUM_W    = PROD_W + 1;

  // coordinate scaling shift
  localparam int SHIFT_W = DETAIL_W + 1;
  localparam int SHIFT_BIAS = 2;

endpackage

// ===== rtl/hbtc_addr.sv =====
// ----------------------------------------------------------------------------
// hbtc_addr
// First pipeline stage: maps the height to two texture indexes and a blend
// fraction, scales and wraps the map coordinate, and forms memory addresses.
// ----------------------------------------------------------------------------
module hbtc_addr #(
  parameter int TEX_WIDTH  = hbtc_pkg::DEF_TEX_WIDTH,
  parameter int TEX_HEIGHT = hbtc_pkg::DEF_TEX_HEIGHT,
  parameter int TEX_COUNT  = hbtc_pkg::DEF_TEX_COUNT,
  localparam int XB     = $clog2(TEX_WIDTH),
  localparam int YB     = $clog2(TEX_HEIGHT),
  localparam int CNT_W  = $clog2(TEX_COUNT),
  localparam int ADDR_W = CNT_W + YB + XB
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hbtc_pkg::detail_t                     detail,
  // incoming item
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  hbtc_pkg::mode_t                       in_mode,
  input  logic [hbtc_pkg::SEL_W-1:0]            in_sel,
  input  logic [hbtc_pkg::IDX_W-1:0]            in_idx,
  input  logic [hbtc_pkg::TEXEL_W-1:0]          in_texel,
  input  logic signed [hbtc_pkg::HEIGHT_W-1:0]  in_height,
  input  logic signed [hbtc_pkg::COORD_W-1:0]   in_cx,
  input  logic signed [hbtc_pkg::COORD_W-1:0]   in_cy,
  // outgoing item
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output hbtc_pkg::mode_t                       out_mode,
  output logic                                  out_we,
  output logic [ADDR_W-1:0]                     out_addr0,
  output logic [ADDR_W-1:0]                     out_addr1,
  output logic [hbtc_pkg::TEXEL_W-1:0]          out_texel,
  output logic [hbtc_pkg::FRAC_BITS-1:0]        out_frac
);
  import hbtc_pkg::*;

  localparam int TEXELS  = TEX_WIDTH * TEX_HEIGHT;
  localparam int TXL_BITS = YB + XB;

  // arithmetic shift by the detail level, left for sh >= 0, else right
  function automatic logic [31:0] scale_coord(input logic signed [COORD_W-1:0] c,
                                              input logic signed [SHIFT_W-1:0] sh);
    logic [31:0]        u;
    logic [SHIFT_W-1:0] neg;
    u   = 32'(c);
    neg = -sh;
    if (!sh[SHIFT_W-1]) begin
      scale_coord = u << sh[SHIFT_W-2:0];
    end else begin
      scale_coord = 32'($signed(u) >>> neg[SHIFT_W-2:0]);
    end
  endfunction

  logic signed [SHIFT_W-1:0] shift_amt;
  logic signed [ZRAW_W-1:0]  h_biased;
  logic signed [ZRAW_W-1:0]  z_raw;
  logic [Z_W-1:0]            z_clamp;
  logic [ZI_W-1:0]           zi;
  logic [ZI_W-1:0]           zi1;
  logic [CNT_W-1:0]          tex0;
  logic [CNT_W-1:0]          tex1;
  logic [31:0]               sx;
  logic [31:0]               sy;
  logic [TXL_BITS-1:0]       pos;
  logic                      sel_ok;
  logic                      idx_ok;
  logic [ADDR_W-1:0]         wr_addr;

  // height to blend position and texture pair
  always_comb begin
    h_biased = ZRAW_W'(in_height) + ZRAW_W'(HEIGHT_BIAS);
    z_raw    = h_biased * ZRAW_W'(HEIGHT_SCALE);
    if (z_raw < 0) begin
      z_clamp = '0;
    end else if (z_raw > ZRAW_W'(Z_MAX)) begin
      z_clamp = Z_W'(Z_MAX);
    end else begin
      z_clamp = z_raw[Z_W-1:0];
    end
    zi  = z_clamp[Z_W-1:FRAC_BITS];
    zi1 = zi + ZI_W'(1);
    tex0 = (32'(zi) > 32'(TEX_COUNT - 1)) ? CNT_W'(TEX_COUNT - 1) : CNT_W'(zi);
    tex1 = (32'(zi1) > 32'(TEX_COUNT - 1)) ? CNT_W'(TEX_COUNT - 1) : CNT_W'(zi1);
  end

  // coordinate scaling and wrap to the texture size
  always_comb begin
    shift_amt = SHIFT_W'(detail) + SHIFT_W'(SHIFT_BIAS);
    sx  = scale_coord(in_cx, shift_amt);
    sy  = scale_coord(in_cy, shift_amt);
    pos = {sy[YB-1:0], sx[XB-1:0]};
  end

  // load address and range check
  always_comb begin
    sel_ok  = 32'(in_sel) < 32'(TEX_COUNT);
    idx_ok  = 32'(in_idx) < 32'(TEXELS);
    wr_addr = {CNT_W'(in_sel), TXL_BITS'(in_idx)};
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_mode  <= in_mode;
      out_we    <= (in_mode == MODE_LOAD) && sel_ok && idx_ok;
      out_addr0 <= (in_mode == MODE_LOAD) ? wr_addr : {tex0, pos};
      out_addr1 <= {tex1, pos};
      out_texel <= in_texel;
      out_frac  <= z_clamp[FRAC_BITS-1:0];
    end
  end

endmodule

// ===== rtl/hbtc_texmem.sv =====
// ----------------------------------------------------------------------------
// hbtc_texmem
// Texture memory stage: loads write one texel, shades read the two texels of
// the blend pair with registered read data.
// ----------------------------------------------------------------------------
module hbtc_texmem #(
  parameter int TEX_WIDTH  = hbtc_pkg::DEF_TEX_WIDTH,
  parameter int TEX_HEIGHT = hbtc_pkg::DEF_TEX_HEIGHT,
  parameter int TEX_COUNT  = hbtc_pkg::DEF_TEX_COUNT,
  localparam int ADDR_W = $clog2(TEX_COUNT) + $clog2(TEX_HEIGHT) + $clog2(TEX_WIDTH)
) (
  input  logic                             clk,
  input  logic                             rst,
  // incoming item
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hbtc_pkg::mode_t                  in_mode,
  input  logic                             in_we,
  input  logic [ADDR_W-1:0]                in_addr0,
  input  logic [ADDR_W-1:0]                in_addr1,
  input  logic [hbtc_pkg::TEXEL_W-1:0]     in_texel,
  input  logic [hbtc_pkg::FRAC_BITS-1:0]   in_frac,
  // outgoing item, shades only
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hbtc_pkg::TEXEL_W-1:0]     out_texel0,
  output logic [hbtc_pkg::TEXEL_W-1:0]     out_texel1,
  output logic [hbtc_pkg::FRAC_BITS-1:0]   out_frac
);
  import hbtc_pkg::*;

  localparam int DEPTH = TEX_COUNT * TEX_WIDTH * TEX_HEIGHT;

  logic [TEXEL_W-1:0] mem [DEPTH];
  logic               fire;
  logic               is_shade;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign is_shade = (in_mode == MODE_SHADE);

  // texel write port
  always_ff @(posedge clk) begin
    if (fire && !is_shade && in_we) begin
      mem[in_addr0] <= in_texel;
    end
  end

  // two registered read ports, held while stalled
  always_ff @(posedge clk) begin
    if (fire && is_shade) begin
      out_texel0 <= mem[in_addr0];
      out_texel1 <= mem[in_addr1];
      out_frac   <= in_frac;
    end
  end

  // loads end here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid && is_shade;
    end
  end

endmodule

// ===== rtl/hbtc_blend.sv =====
// ----------------------------------------------------------------------------
// hbtc_blend
// Two-stage linear blend of two texels per channel: weighted products, then
// sum and truncation to 8 bits.
// ----------------------------------------------------------------------------
module hbtc_blend (
  input  logic                             clk,
  input  logic                             rst,
  // incoming item
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hbtc_pkg::TEXEL_W-1:0]     in_texel0,
  input  logic [hbtc_pkg::TEXEL_W-1:0]     in_texel1,
  input  logic [hbtc_pkg::FRAC_BITS-1:0]   in_frac,
  // outgoing item
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hbtc_pkg::TEXEL_W-1:0]     out_texel
);
  import hbtc_pkg::*;

  logic [WEIGHT_W-1:0] w0;
  logic [WEIGHT_W-1:0] w1;
  logic [PROD_W-1:0]   prod0 [3];
  logic [PROD_W-1:0]   prod1 [3];
  logic                prod_valid;
  logic                prod_ready;
  logic [SUM_W-1:0]    sum   [3];

  assign w1 = WEIGHT_W'(in_frac);
  assign w0 = WEIGHT_W'(FRAC_ONE) - w1;

  assign prod_ready = !out_valid || out_ready;
  assign in_ready   = !prod_valid || prod_ready;

  // product stage, one lane per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int c = 0; c < 3; c++) begin
        prod0[c] <= PROD_W'(in_texel0[c*CHAN_W +: CHAN_W]) * PROD_W'(w0);
        prod1[c] <= PROD_W'(in_texel1[c*CHAN_W +: CHAN_W]) * PROD_W'(w1);
      end
    end
  end

  // sum and truncate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SUM_W'(prod0[c]) + SUM_W'(prod1[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      for (int c = 0; c < 3; c++) begin
        out_texel[c*CHAN_W +: CHAN_W] <= sum[c][FRAC_BITS +: CHAN_W];
      end
    end
  end

endmodule

// ===== rtl/height_blended_texture_color.sv =====
// ----------------------------------------------------------------------------
// height_blended_texture_color
// Terrain shader: texel loads into eight textures and height based blending
// of two textures at a scaled, wrapped map coordinate.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one item per transfer. tuser selects the kind: a load
//   writes one RGB texel into the texture memory and gives no result, a shade
//   gives one blended RGB result on m_axis.
//   cfg writes the signed 4-bit detail level; write it only while no item is
//   in flight.
// Throughput and pipeline
//   One item per cycle while m_axis is not stalled. A shade result reaches
//   m_axis through the address stage, texture memory read, weighted
//   products and sum, in that order. The two registered read ports of the
//   texture memory set this pace, one shade per cycle.
// Reset
//   rst clears the pipeline valid bits and sets the detail level to zero.
//   The texture memory is not cleared; a texel must be loaded before a shade
//   reads it.
// Backpressure
//   Each stage holds its item while the next is full, so a stall on m_axis
//   fills the bubbles and then drops s_axis_tready; nothing is lost.
// ----------------------------------------------------------------------------
`include "height_blended_texture_color_defines.svh"

module height_blended_texture_color #(
  parameter int TEX_WIDTH  = hbtc_pkg::DEF_TEX_WIDTH,
  parameter int TEX_HEIGHT = hbtc_pkg::DEF_TEX_HEIGHT,
  parameter int TEX_COUNT  = hbtc_pkg::DEF_TEX_COUNT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  hbtc_pkg::detail_t                  cfg_data,      // detail_level
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // texture_select, texel_index, texel_red, texel_green, texel_blue,
  // height, coord_x, coord_y, zero fill
  input  logic [hbtc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tuser,  // mode
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [hbtc_pkg::M_TDATA_W-1:0]     m_axis_tdata   // out_red, out_green, out_blue
);
  import hbtc_pkg::*;

  localparam int ADDR_W = $clog2(TEX_COUNT) + $clog2(TEX_HEIGHT) + $clog2(TEX_WIDTH);

  detail_t                      detail;
  logic [TEXEL_W-1:0]           in_texel;

  logic                         am_valid;
  logic                         am_ready;
  mode_t                        am_mode;
  logic                         am_we;
  logic [ADDR_W-1:0]            am_addr0;
  logic [ADDR_W-1:0]            am_addr1;
  logic [TEXEL_W-1:0]           am_texel;
  logic [FRAC_BITS-1:0]         am_frac;

  logic                         mb_valid;
  logic                         mb_ready;
  logic [TEXEL_W-1:0]           mb_texel0;
  logic [TEXEL_W-1:0]           mb_texel1;
  logic [FRAC_BITS-1:0]         mb_frac;

  logic [TEXEL_W-1:0]           out_texel;

  // detail level register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      detail <= DETAIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      detail <= cfg_data;
    end
  end

  // texel memory word: red high, blue low
  assign in_texel = {s_axis_tdata[RED_LSB +: CHAN_W],
                     s_axis_tdata[GREEN_LSB +: CHAN_W],
                     s_axis_tdata[BLUE_LSB +: CHAN_W]};

  hbtc_addr #(
    .TEX_WIDTH  (TEX_WIDTH),
    .TEX_HEIGHT (TEX_HEIGHT),
    .TEX_COUNT  (TEX_COUNT)
  ) u_addr (
    .clk       (clk),
    .rst       (rst),
    .detail    (detail),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (mode_t'(s_axis_tuser)),
    .in_sel    (s_axis_tdata[SEL_LSB +: SEL_W]),
    .in_idx    (s_axis_tdata[IDX_LSB +: IDX_W]),
    .in_texel  (in_texel),
    .in_height (s_axis_tdata[HEIGHT_LSB +: HEIGHT_W]),
    .in_cx     (s_axis_tdata[CX_LSB +: COORD_W]),
    .in_cy     (s_axis_tdata[CY_LSB +: COORD_W]),
    .out_valid (am_valid),
    .out_ready (am_ready),
    .out_mode  (am_mode),
    .out_we    (am_we),
    .out_addr0 (am_addr0),
    .out_addr1 (am_addr1),
    .out_texel (am_texel),
    .out_frac  (am_frac)
  );

  hbtc_texmem #(
    .TEX_WIDTH  (TEX_WIDTH),
    .TEX_HEIGHT (TEX_HEIGHT),
    .TEX_COUNT  (TEX_COUNT)
  ) u_texmem (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (am_valid),
    .in_ready   (am_ready),
    .in_mode    (am_mode),
    .in_we      (am_we),
    .in_addr0   (am_addr0),
    .in_addr1   (am_addr1),
    .in_texel   (am_texel),
    .in_frac    (am_frac),
    .out_valid  (mb_valid),
    .out_ready  (mb_ready),
    .out_texel0 (mb_texel0),
    .out_texel1 (mb_texel1),
    .out_frac   (mb_frac)
  );

  hbtc_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mb_valid),
    .in_ready  (mb_ready),
    .in_texel0 (mb_texel0),
    .in_texel1 (mb_texel1),
    .in_frac   (mb_frac),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_texel (out_texel)
  );

  // result layout: red lowest
  assign m_axis_tdata = {out_texel[0 +: CHAN_W],
                         out_texel[CHAN_W +: CHAN_W],
                         out_texel[2*CHAN_W +: CHAN_W]};

  // checks
  `HBTC_ASSERT_ALWAYS(a_reset_empties_output, clk, rst |=> !m_axis_tvalid)
  `HBTC_ASSERT(a_empty_output_takes_item, clk, rst, !m_axis_tvalid |-> s_axis_tready)
  `HBTC_ASSERT(a_load_gives_no_result, clk, rst, am_valid && am_ready && am_mode == MODE_LOAD |=> !mb_valid)
  `HBTC_ASSERT(a_shade_reaches_blend, clk, rst, am_valid && am_ready && am_mode == MODE_SHADE |=> mb_valid)

endmodule

// ===== bench/tb_height_blended_texture_color.sv =====
// ----------------------------------------------------------------------------
// tb_height_blended_texture_color
// Self-checking bench for the height blended texture color shader. Texel loads
// and shade items go in on s_axis; a local copy of the texture memory and the
// detail level predicts every blended color, and results from m_axis are
// compared channel by channel. A short table of hand-picked items comes
// first, then random load/shade sequences under several detail levels, with
// random idling on both streams, one long output stall and drains between
// phases.
// ----------------------------------------------------------------------------
module tb_height_blended_texture_color;
  timeunit 1ns;
  timeprecision 1ps;

  import hbtc_pkg::*;

  localparam int TEXELS        = DEF_TEX_WIDTH * DEF_TEX_HEIGHT;
  localparam int TEX_TOTAL     = DEF_TEX_COUNT * TEXELS;
  localparam int IDLE_PCT      = 26;
  localparam int NOISE_PCT     = 15;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 143;
  localparam int HOLD_AFTER    = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 21;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    mode_t                      mode;
    logic [SEL_W-1:0]           sel;
    logic [IDX_W-1:0]           idx;
    rgb_t                       color;
    logic signed [HEIGHT_W-1:0] height;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
  } pixel_item_t;

  // pinned rows carry a color that follows directly from the loads above them
  typedef struct packed {
    pixel_item_t item;
    logic        pinned;
    rgb_t        color;
  } stim_row_t;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  detail_t              cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // local copy of the block state
  rgb_t    texel_store  [TEX_TOTAL];
  bit      texel_loaded [TEX_TOTAL];
  detail_t detail_now = DETAIL_RESET;

  rgb_t blended_q [$];
  int   failures     = 0;
  int   colors_seen  = 0;
  int   quiet_cycles = 0;
  bit   steady       = 1'b0;

  int phase_detail [8] = '{7, -8, -2, -3, 3, -5, 6, -1};

  // directed items, all at detail level 0 where coordinate 0 lands on texel 0
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{MODE_LOAD,  3'd0, 16'd0,     24'hff0080, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd1, 16'd0,     24'h00ff7f, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd2, 16'd0,     24'h4080c0, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd3, 16'd0,     24'h123456, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd4, 16'd0,     24'habcdef, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd5, 16'd0,     24'h010203, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd6, 16'd0,     24'h112233, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd7, 16'd0,     24'h112233, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    // lowest height clamps to texture 0 with no blend
    '{'{MODE_SHADE, 3'd0, 16'd0,     24'h0,      16'hc000,    21'sd0,     21'sd0},
      1'b1, 24'hff0080},
    // blend position exactly zero
    '{'{MODE_SHADE, 3'd0, 16'd0,     24'h0,      -16'sd8192,  21'sd0,     21'sd0},
      1'b1, 24'hff0080},
    // top height clamps just below 7, textures 6 and 7 are equal
    '{'{MODE_SHADE, 3'd0, 16'd0,     24'h0,      16'sd16384,  21'sd0,     21'sd0},
      1'b1, 24'h112233},
    '{'{MODE_SHADE, 3'd0, 16'd0,     24'h0,      16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_SHADE, 3'd0, 16'd0,     24'h0,      16'sd8191,   21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd0, 16'd252,   24'h000000, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd1, 16'd252,   24'hffffff, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    // coordinate extremes wrap to texel 252 of row 0
    '{'{MODE_SHADE, 3'd0, 16'd0,     24'h0,      -16'sd10000, 21'h0fffff, 21'h100000},
      1'b1, 24'h000000},
    '{'{MODE_SHADE, 3'd0, 16'd0,     24'h0,      -16'sd7000,  21'h0fffff, 21'h100000},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd3, 16'hfcfc,  24'h5aa53c, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd4, 16'hfcfc,  24'hc33c99, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0},
    // negative coordinates wrap to texel 252 of row 252
    '{'{MODE_SHADE, 3'd0, 16'd0,     24'h0,      16'sd0,      -21'sd1,    -21'sd1},
      1'b0, 24'h0},
    '{'{MODE_LOAD,  3'd7, 16'hffff,  24'h7f8001, 16'sd0,      21'sd0,     21'sd0},
      1'b0, 24'h0}
  };

  height_blended_texture_color i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // scale a coordinate by the detail level and wrap it to the texture size
  function automatic int wrap_coord(input logic signed [COORD_W-1:0] c, input detail_t dl,
                                    input int span);
    int v;
    int shift;
    v = c;
    shift = int'(dl) + SHIFT_BIAS;
    if (shift >= 0) begin
      v = v << shift;
    end else begin
      v = v >>> -shift;
    end
    return v & (span - 1);
  endfunction

  // texel position, the two textures and the blend fraction of a shade item
  function automatic void shade_taps(input pixel_item_t it, input detail_t dl, output int pos,
                                     output int lo_tex, output int hi_tex, output int frac);
    int z;
    z = (int'(it.height) + HEIGHT_BIAS) * HEIGHT_SCALE;
    if (z < 0) z = 0;
    if (z > Z_MAX) z = Z_MAX;
    frac   = z % FRAC_ONE;
    lo_tex = z / FRAC_ONE;
    hi_tex = lo_tex + 1;
    if (lo_tex > DEF_TEX_COUNT - 1) lo_tex = DEF_TEX_COUNT - 1;
    if (hi_tex > DEF_TEX_COUNT - 1) hi_tex = DEF_TEX_COUNT - 1;
    pos = wrap_coord(it.cy, dl, DEF_TEX_HEIGHT) * DEF_TEX_WIDTH
        + wrap_coord(it.cx, dl, DEF_TEX_WIDTH);
  endfunction

  // linear blend of one channel, truncated
  function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b, input int frac);
    return CHAN_W'((int'(a) * (FRAC_ONE - frac) + int'(b) * frac) >>> FRAC_BITS);
  endfunction

  function automatic pixel_item_t random_item(input mode_t m);
    pixel_item_t it;
    it.mode   = m;
    it.sel    = SEL_W'($urandom_range(0, 7));
    it.idx    = IDX_W'($urandom);
    it.color  = TEXEL_W'($urandom);
    it.height = HEIGHT_W'($urandom_range(0, 32768) - 16384);
    it.cx     = COORD_W'($urandom);
    it.cy     = COORD_W'($urandom);
    return it;
  endfunction

  // offer one item; once taken, update the texture copy or queue its color
  task automatic offer_item(input pixel_item_t it, input bit pinned, input rgb_t pinned_color);
    logic [S_TDATA_W-1:0] word;
    rgb_t lo_texel;
    rgb_t hi_texel;
    int pos;
    int lo_tex;
    int hi_tex;
    int frac;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    word = '0;
    word[SEL_LSB +: SEL_W]       = it.sel;
    word[IDX_LSB +: IDX_W]       = it.idx;
    word[RED_LSB +: CHAN_W]      = it.color.red;
    word[GREEN_LSB +: CHAN_W]    = it.color.green;
    word[BLUE_LSB +: CHAN_W]     = it.color.blue;
    word[HEIGHT_LSB +: HEIGHT_W] = it.height;
    word[CX_LSB +: COORD_W]      = it.cx;
    word[CY_LSB +: COORD_W]      = it.cy;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= it.mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (it.mode == MODE_LOAD) begin
      if (int'(it.sel) < DEF_TEX_COUNT && int'(it.idx) < TEXELS) begin
        texel_store[int'(it.sel) * TEXELS + int'(it.idx)]  = it.color;
        texel_loaded[int'(it.sel) * TEXELS + int'(it.idx)] = 1'b1;
      end
    end else if (pinned) begin
      blended_q.push_back(pinned_color);
    end else begin
      shade_taps(it, detail_now, pos, lo_tex, hi_tex, frac);
      lo_texel = texel_store[lo_tex * TEXELS + pos];
      hi_texel = texel_store[hi_tex * TEXELS + pos];
      blended_q.push_back({mix_channel(lo_texel.red, hi_texel.red, frac),
                           mix_channel(lo_texel.green, hi_texel.green, frac),
                           mix_channel(lo_texel.blue, hi_texel.blue, frac)});
    end
  endtask

  // random shades, preceded by loads of texels they read that are missing, plus stray loads
  task automatic shade_phase(input int n_items);
    pixel_item_t it;
    pixel_item_t ld;
    int made;
    int pos;
    int lo_tex;
    int hi_tex;
    int frac;
    int taps [2];
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < NOISE_PCT) begin
        offer_item(random_item(MODE_LOAD), 1'b0, '0);
        made++;
      end else begin
        it = random_item(MODE_SHADE);
        shade_taps(it, detail_now, pos, lo_tex, hi_tex, frac);
        taps[0] = lo_tex;
        taps[1] = hi_tex;
        // missing texels always, loaded ones now and then for overwrite hazards
        foreach (taps[k]) begin
          if (!texel_loaded[taps[k] * TEXELS + pos] || $urandom_range(0, 3) == 0) begin
            ld     = random_item(MODE_LOAD);
            ld.sel = SEL_W'(taps[k]);
            ld.idx = IDX_W'(pos);
            offer_item(ld, 1'b0, '0);
            made++;
          end
        end
        offer_item(it, 1'b0, '0);
        made++;
      end
    end
  endtask

  task automatic write_detail(input detail_t dl);
    cfg_valid <= 1'b1;
    cfg_data  <= dl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    detail_now = dl;
  endtask

  // stop sending, wait for every color, then let trailing loads retire
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_channel(input string chan, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
      failures++;
    end
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].color);
    end
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      steady = (p == 2);
      if (p < 8) begin
        write_detail(detail_t'(phase_detail[p]));
      end else begin
        write_detail(detail_t'($urandom_range(0, 15)));
      end
      shade_phase(PHASE_ITEMS);
    end
    steady = 1'b0;
    drain_results();
    if (failures == 0) begin
      $display("height_blended_texture_color test passed");
    end else begin
      $display("height_blended_texture_color test failed");
    end
    $finish;
  end

  // result side: check each color, random stalls, one long hold-off
  initial begin
    rgb_t got;
    rgb_t want;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[CHAN_W-1:0], m_axis_tdata[2*CHAN_W-1:CHAN_W],
               m_axis_tdata[3*CHAN_W-1:2*CHAN_W]};
        if (blended_q.size() == 0) begin
          $display("%0t: color %h with none expected", $time, m_axis_tdata);
          failures++;
        end else begin
          want = blended_q.pop_front();
          check_channel("red", want.red, got.red);
          check_channel("green", want.green, got.green);
          check_channel("blue", want.blue, got.blue);
        end
        colors_seen++;
      end
      if (!held && colors_seen >= HOLD_AFTER) begin
        // long stall so the pipeline fills and the input backs up
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no item moving anywhere
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("height_blended_texture_color test failed");
      $finish;
    end
  end

endmodule
